@@ sv/wsu_pkg.sv @@
package wsu_pkg;

  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_X_COEFF = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_Y_COEFF = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TAU_SQ  = 2'd2;

  typedef struct packed {
    logic signed [31:0] u_center;
    logic signed [31:0] u_left;
    logic signed [31:0] u_right;
    logic signed [31:0] u_row_minus;
    logic signed [31:0] u_row_plus;
    logic signed [31:0] u_old;
    logic [30:0]        p_here;
    logic [30:0]        p_left;
    logic [30:0]        p_row_minus;
    logic [30:0]        p_row_minus_left;
    logic signed [31:0] source_term;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] u_next;
    logic [30:0]        peak_value;
  } out_word_t;

  typedef struct packed {
    logic [31:0] x_coeff;
    logic [31:0] y_coeff;
    logic [31:0] tau_sq;
  } coef_t;

  // Pre-classified word: neighbor differences in sign/magnitude form,
  // matching speed sums, 2*u_center - u_old and the source value.
  // Lane order: x plus, x minus, y plus, y minus.
  typedef struct packed {
    logic [3:0]         neg;
    logic [3:0][32:0]   mag;
    logic [3:0][31:0]   psum;
    logic signed [33:0] base;
    logic signed [31:0] src;
  } work_t;

  typedef struct packed {
    logic  empty;
    work_t head;
  } queue_status_t;

endpackage

@@ sv/wsu_front.sv @@
module wsu_front (
  input  logic              in_valid,
  output logic              in_stall,
  input  wsu_pkg::in_word_t in_word,
  input  logic              q_full,
  output logic              q_push,
  output wsu_pkg::work_t    q_entry
);
  import wsu_pkg::*;

  logic signed [32:0] d_xp, d_xm, d_yp, d_ym;

  function automatic logic [32:0] mag33(input logic signed [32:0] v);
    logic [32:0] m;
    m = v[32] ? (33'd0 - v) : v;
    return m;
  endfunction

  assign d_xp = {in_word.u_right[31], in_word.u_right}
              - {in_word.u_center[31], in_word.u_center};
  assign d_xm = {in_word.u_left[31], in_word.u_left}
              - {in_word.u_center[31], in_word.u_center};
  assign d_yp = {in_word.u_row_plus[31], in_word.u_row_plus}
              - {in_word.u_center[31], in_word.u_center};
  assign d_ym = {in_word.u_row_minus[31], in_word.u_row_minus}
              - {in_word.u_center[31], in_word.u_center};

  always_comb begin
    q_entry.neg     = {d_ym[32], d_yp[32], d_xm[32], d_xp[32]};
    q_entry.mag[0]  = mag33(d_xp);
    q_entry.mag[1]  = mag33(d_xm);
    q_entry.mag[2]  = mag33(d_yp);
    q_entry.mag[3]  = mag33(d_ym);
    q_entry.psum[0] = {1'b0, in_word.p_row_minus} + {1'b0, in_word.p_here};
    q_entry.psum[1] = {1'b0, in_word.p_row_minus_left} + {1'b0, in_word.p_left};
    q_entry.psum[2] = {1'b0, in_word.p_left} + {1'b0, in_word.p_here};
    q_entry.psum[3] = {1'b0, in_word.p_row_minus_left} + {1'b0, in_word.p_row_minus};
    q_entry.base    = {in_word.u_center[31], in_word.u_center, 1'b0}
                    - {{2{in_word.u_old[31]}}, in_word.u_old};
    q_entry.src     = in_word.source_term;
  end

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

endmodule

@@ sv/wsu_fifo.sv @@
module wsu_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  wsu_pkg::work_t         push_entry,
  output logic                   full,
  input  logic                   pop,
  output wsu_pkg::queue_status_t status
);
  import wsu_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  work_t            mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full         = (count_r == CNT_W'(DEPTH));
  assign status.empty = (count_r == '0);
  assign status.head  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

@@ sv/wsu_back.sv @@
module wsu_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  wsu_pkg::coef_t         coef,
  input  wsu_pkg::queue_status_t q_status,
  output logic                   q_pop,
  output logic                   out_valid,
  input  logic                   out_stall,
  output wsu_pkg::out_word_t     out_word
);
  import wsu_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_FIN
  } state_t;

  typedef enum logic [3:0] {
    STEP_XP,
    STEP_XM,
    STEP_YP,
    STEP_YM,
    STEP_X_LO,
    STEP_X_HI,
    STEP_Y_LO,
    STEP_Y_HI,
    STEP_S_LO,
    STEP_S_HI
  } step_t;

  localparam logic signed [63:0] SCALE_LIM  = 64'sh0000_0100_0000_0000;
  localparam logic signed [42:0] OUT_MAX    = 43'sd2147483647;
  localparam logic signed [42:0] OUT_MIN    = -43'sd2147483648;

  state_t             state_r;
  step_t              step_r;
  work_t              work_r;
  logic [64:0]        prod_r;
  logic [63:0]        lo_r;
  logic signed [41:0] xs_r, ys_r;
  logic signed [63:0] sum_r;
  logic signed [41:0] scaled_r;
  logic [30:0]        peak_r;
  logic               out_valid_r;
  out_word_t          out_word_r;

  logic [41:0]        xs_mag, ys_mag;
  logic [63:0]        sum_mag;
  logic [32:0]        mul_a;
  logic [31:0]        mul_b;
  logic [64:0]        mul_p;
  logic [64:0]        rnd24;
  logic signed [41:0] lane_term;
  logic [95:0]        wide_sum;
  logic [63:0]        wide_mag;
  logic               wide_neg;
  logic signed [63:0] wide_term;
  logic signed [41:0] scaled_nxt;
  logic signed [42:0] total;
  logic signed [31:0] total_sat;
  logic [30:0]        peak_nxt;
  logic               out_free;

  assign xs_mag  = xs_r[41] ? (42'd0 - xs_r) : xs_r;
  assign ys_mag  = ys_r[41] ? (42'd0 - ys_r) : ys_r;
  assign sum_mag = sum_r[63] ? (64'd0 - sum_r) : sum_r;

  // one shared 33x32 multiplier; wide operands go through in two halves
  always_comb begin
    unique case (step_r)
      STEP_XP:   begin mul_a = work_r.mag[0]; mul_b = work_r.psum[0]; end
      STEP_XM:   begin mul_a = work_r.mag[1]; mul_b = work_r.psum[1]; end
      STEP_YP:   begin mul_a = work_r.mag[2]; mul_b = work_r.psum[2]; end
      STEP_YM:   begin mul_a = work_r.mag[3]; mul_b = work_r.psum[3]; end
      STEP_X_LO: begin mul_a = {1'b0, xs_mag[31:0]};  mul_b = coef.x_coeff; end
      STEP_X_HI: begin mul_a = 33'(xs_mag[41:32]);    mul_b = coef.x_coeff; end
      STEP_Y_LO: begin mul_a = {1'b0, ys_mag[31:0]};  mul_b = coef.y_coeff; end
      STEP_Y_HI: begin mul_a = 33'(ys_mag[41:32]);    mul_b = coef.y_coeff; end
      STEP_S_LO: begin mul_a = {1'b0, sum_mag[31:0]};  mul_b = coef.tau_sq; end
      STEP_S_HI: begin mul_a = {1'b0, sum_mag[63:32]}; mul_b = coef.tau_sq; end
      default:   begin mul_a = '0; mul_b = '0; end
    endcase
    mul_p = 65'(mul_a) * 65'(mul_b);
  end

  // lane product: round magnitude by 24 bits, then restore sign
  always_comb begin
    rnd24     = prod_r + 65'h80_0000;
    lane_term = work_r.neg[step_r[1:0]] ? (42'd0 - {2'b00, rnd24[63:24]})
                                        : {2'b00, rnd24[63:24]};
  end

  // recombine the two halves and round by 12 (coefficients) or 32 (tau)
  always_comb begin
    if (step_r == STEP_S_HI) begin
      wide_sum = {prod_r[63:0], 32'd0} + {32'd0, lo_r} + 96'h8000_0000;
      wide_mag = wide_sum[95:32];
    end else begin
      wide_sum = {prod_r[63:0], 32'd0} + {32'd0, lo_r} + 96'h800;
      wide_mag = wide_sum[75:12];
    end
    unique case (step_r)
      STEP_X_HI: wide_neg = xs_r[41];
      STEP_Y_HI: wide_neg = ys_r[41];
      default:   wide_neg = sum_r[63];
    endcase
    wide_term = wide_neg ? (64'sd0 - $signed(wide_mag)) : $signed(wide_mag);
    if (wide_term > SCALE_LIM) begin
      scaled_nxt = SCALE_LIM[41:0];
    end else if (wide_term < -SCALE_LIM) begin
      scaled_nxt = -SCALE_LIM[41:0];
    end else begin
      scaled_nxt = wide_term[41:0];
    end
  end

  always_comb begin
    total = {{9{work_r.base[33]}}, work_r.base} + {scaled_r[41], scaled_r};
    if (total > OUT_MAX) begin
      total_sat = 32'sh7FFF_FFFF;
    end else if (total < OUT_MIN) begin
      total_sat = 32'sh8000_0000;
    end else begin
      total_sat = total[31:0];
    end
    if (!total_sat[31] && (total_sat != 32'sd0) && (total_sat[30:0] > peak_r)) begin
      peak_nxt = total_sat[30:0];
    end else begin
      peak_nxt = peak_r;
    end
  end

  assign out_free  = !out_valid_r || !out_stall;
  assign q_pop     = (state_r == ST_IDLE) && !q_status.empty;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= STEP_XP;
      peak_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // the finish state reloads the output register itself
      if (out_valid_r && !out_stall && (state_r != ST_FIN)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (!q_status.empty) begin
            work_r  <= q_status.head;
            xs_r    <= '0;
            ys_r    <= '0;
            sum_r   <= {{32{q_status.head.src[31]}}, q_status.head.src};
            step_r  <= STEP_XP;
            state_r <= ST_MUL;
          end
        end
        ST_MUL: begin
          prod_r  <= mul_p;
          state_r <= ST_ACC;
        end
        ST_ACC: begin
          unique case (step_r)
            STEP_XP, STEP_XM:               xs_r     <= xs_r + lane_term;
            STEP_YP, STEP_YM:               ys_r     <= ys_r + lane_term;
            STEP_X_LO, STEP_Y_LO, STEP_S_LO: lo_r    <= prod_r[63:0];
            STEP_X_HI, STEP_Y_HI:           sum_r    <= sum_r + wide_term;
            STEP_S_HI:                      scaled_r <= scaled_nxt;
            default:                        lo_r     <= lo_r;
          endcase
          if (step_r == STEP_S_HI) begin
            state_r <= ST_FIN;
          end else begin
            step_r  <= step_t'(step_r + 4'd1);
            state_r <= ST_MUL;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            out_word_r.u_next     <= total_sat;
            out_word_r.peak_value <= peak_nxt;
            peak_r                <= peak_nxt;
            out_valid_r           <= 1'b1;
            state_r               <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ sv/wave_stencil_update.sv @@
// Channel   Direction  Handshake                 Word
// in_       input      in_valid / in_stall       in_word  (wsu_pkg::in_word_t)
// out_      output     out_valid / out_stall     out_word (wsu_pkg::out_word_t)
// cfg_      input      cfg_valid / cfg_ready     cfg_index, cfg_data
//
// The back end loads one word at a time, then puts ten partial products through
// one shared 33x32 multiplier, each in states MUL and ACC, then FIN outputs it.
// The front classifies a word in the cycle it is accepted and queues it, so
// QUEUE_DEPTH words can wait while the back end works or out_stall holds it.
// Synchronous active-low reset clears the queue, coefficients and the peak.
module wave_stencil_update #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  wsu_pkg::in_word_t               in_word,
  output logic                            out_valid,
  input  logic                            out_stall,
  output wsu_pkg::out_word_t              out_word,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [wsu_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [31:0]                     cfg_data
);
  import wsu_pkg::*;

  coef_t         coef_r;
  logic          q_full, q_push, q_pop;
  work_t         q_entry;
  queue_status_t q_status;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_X_COEFF: coef_r.x_coeff <= cfg_data;
        REG_Y_COEFF: coef_r.y_coeff <= cfg_data;
        REG_TAU_SQ:  coef_r.tau_sq  <= cfg_data;
        default:     coef_r         <= coef_r;
      endcase
    end
  end

  wsu_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_entry  (q_entry)
  );

  wsu_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .status     (q_status)
  );

  wsu_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .coef      (coef_r),
    .q_status  (q_status),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule
